/* hdl/dmsc_pkg.sv */
// ----------------------------------------------------------------------------
// dmsc_pkg
// Shared constants and command types for the direct-mapped string cache.
// ----------------------------------------------------------------------------
package dmsc_pkg;

    localparam int HASH_SEED  = 5381;
    localparam int HASH_SHIFT = 5;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_MISS   = 2'd1,
        OUT_BYPASS = 2'd2
    } t_outcome;

    // control from the sequencer to the string collector
    typedef struct packed {
        logic take;     // accepted item carries a byte
        logic restart;  // string finished, return hash and count to start
        logic rd_en;    // read the incoming buffer
    } t_collect_cmd;

    // control from the sequencer to the entry store
    typedef struct packed {
        logic len_rd;
        logic len_wr;
        logic txt_rd;
        logic txt_wr;
    } t_entry_cmd;

endpackage

/* hdl/dmsc_collect.sv */
// ----------------------------------------------------------------------------
// dmsc_collect
// Streams string bytes: djb2 hash (low slot bits), byte count and the
// incoming byte buffer with one registered read port.
// ----------------------------------------------------------------------------
module dmsc_collect #(
    parameter int SLOTS   = 64,
    parameter int MAX_LEN = 32,
    localparam int SW = $clog2(SLOTS),
    localparam int CW = $clog2(MAX_LEN + 2),
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dmsc_pkg::t_collect_cmd i_cmd,
    input  logic [7:0]             i_data_byte,
    input  logic [IW-1:0]          i_rd_idx,
    output logic [7:0]             o_rd_byte,
    output logic [SW-1:0]          o_hash,
    output logic [CW-1:0]          o_count
);
    import dmsc_pkg::*;

    localparam logic [SW-1:0] HASH_INIT = SW'(HASH_SEED % SLOTS);

    logic [SW-1:0] r_hash;
    logic [SW-1:0] n_hash;
    logic [CW-1:0] r_count;
    logic          w_room;
    logic [7:0]    r_buf [MAX_LEN];
    logic [7:0]    r_rd_byte;

    assign w_room = (r_count < CW'(MAX_LEN));
    assign n_hash = r_hash + (r_hash << HASH_SHIFT) + SW'(i_data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= HASH_INIT;
            r_count <= '0;
        end else if (i_cmd.restart) begin
            r_hash  <= HASH_INIT;
            r_count <= '0;
        end else if (i_cmd.take) begin
            if (w_room) begin
                r_hash  <= n_hash;
                r_count <= r_count + CW'(1);
            end else begin
                r_count <= CW'(MAX_LEN + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && w_room) begin
            r_buf[r_count[IW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_byte <= r_buf[i_rd_idx];
        end
    end

    assign o_rd_byte = r_rd_byte;
    assign o_hash    = r_hash;
    assign o_count   = r_count;

endmodule

/* hdl/dmsc_entry.sv */
// ----------------------------------------------------------------------------
// dmsc_entry
// Entry store: text memory (slot x byte) and length memory. A stored length
// of zero marks an empty slot; the length memory is swept to zero after reset.
// ----------------------------------------------------------------------------
module dmsc_entry #(
    parameter int SLOTS   = 64,
    parameter int MAX_LEN = 32,
    localparam int SW  = $clog2(SLOTS),
    localparam int LW  = $clog2(MAX_LEN + 1),
    localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int TAW = $clog2(SLOTS * MAX_LEN)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dmsc_pkg::t_entry_cmd i_cmd,
    input  logic [SW-1:0]        i_slot,
    input  logic [IW-1:0]        i_rd_idx,
    input  logic [IW-1:0]        i_wr_idx,
    input  logic [7:0]           i_wr_byte,
    input  logic [LW-1:0]        i_len_wdata,
    output logic [7:0]           o_txt_rdata,
    output logic [LW-1:0]        o_len_rdata,
    output logic                 o_busy
);
    import dmsc_pkg::*;

    logic [7:0]     r_txt [SLOTS * MAX_LEN];
    logic [LW-1:0]  r_len [SLOTS];
    logic [7:0]     r_txt_rdata;
    logic [LW-1:0]  r_len_rdata;
    logic           r_clr_busy;
    logic [SW-1:0]  r_clr_idx;
    logic [TAW-1:0] w_base;
    logic [TAW-1:0] w_rd_addr;
    logic [TAW-1:0] w_wr_addr;

    assign w_base    = TAW'(i_slot) * TAW'(MAX_LEN);
    assign w_rd_addr = w_base + TAW'(i_rd_idx);
    assign w_wr_addr = w_base + TAW'(i_wr_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + SW'(1);
            if (r_clr_idx == SW'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_len[r_clr_idx] <= '0;
        end else if (i_cmd.len_wr) begin
            r_len[i_slot] <= i_len_wdata;
        end
        if (i_cmd.len_rd) begin
            r_len_rdata <= r_len[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.txt_wr) begin
            r_txt[w_wr_addr] <= i_wr_byte;
        end
        if (i_cmd.txt_rd) begin
            r_txt_rdata <= r_txt[w_rd_addr];
        end
    end

    assign o_txt_rdata = r_txt_rdata;
    assign o_len_rdata = r_len_rdata;
    assign o_busy      = r_clr_busy;

endmodule

/* hdl/direct_mapped_string_cache.sv */
// ----------------------------------------------------------------------------
// direct_mapped_string_cache
// Direct-mapped string cache keyed by the djb2 hash of the string.
//
// Input channel (i_valid / o_stall): one transfer per string byte, with
// i_last on the final transfer. i_empty_req on a transfer means it carries
// no byte; with i_last low it is ignored, with i_last high it ends the string
// (a string with no bytes is reported as bypass).
// Output channel (o_valid / i_stall): one transfer per string, holding the
// outcome (hit, miss and stored, bypass), slot, length and store count.
// Bytes are taken one per cycle while o_stall is low. After the final byte the
// block performs the slot lookup, then compares the string byte by byte
// against the slot's text memory while rewriting it, then finishes in a tail
// step and registers the result (a bypass skips the comparison and the tail),
// with o_stall high meanwhile.
// The output register holds a result until taken, and bytes of the next
// string stream in meanwhile; a finished string waits only if the previous
// result is still stalled.
// After reset the length memory is swept, with o_stall high.
// SLOTS must be a power of two.
// ----------------------------------------------------------------------------
module direct_mapped_string_cache #(
    parameter int SLOTS   = 64,
    parameter int MAX_LEN = 32,
    localparam int SW  = $clog2(SLOTS),
    localparam int LW  = $clog2(MAX_LEN + 1),
    localparam int STW = $clog2(SLOTS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last,
    input  logic           i_empty_req,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_outcome,
    output logic [SW-1:0]  o_slot,
    output logic [LW-1:0]  o_length,
    output logic [STW-1:0] o_stores
);
    import dmsc_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_STREAM  = 6'b000010,
        ST_DECIDE  = 6'b000100,
        ST_COMPARE = 6'b001000,
        ST_TAIL    = 6'b010000,
        ST_RESULT  = 6'b100000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    t_collect_cmd   w_ccmd;
    t_entry_cmd     w_ecmd;

    logic [SW-1:0]  r_slot;
    logic [LW-1:0]  r_len;
    logic           r_bypass;
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_cidx;
    logic           r_cv;
    logic           r_diff;
    logic [STW-1:0] r_stores;
    logic           r_ovalid;
    t_outcome       r_outcome;
    logic [SW-1:0]  r_oslot;
    logic [LW-1:0]  r_olen;
    logic [STW-1:0] r_ostores;

    logic [7:0]     w_buf_byte;
    logic [SW-1:0]  w_hash;
    logic [CW-1:0]  w_count;
    logic [7:0]     w_txt_rdata;
    logic [LW-1:0]  w_len_rdata;
    logic           w_clr_busy;
    logic [SW-1:0]  w_ent_slot;

    logic           w_accept;
    logic           w_bypass;
    logic           w_out_free;
    logic           w_hit;
    logic           w_store;
    logic [STW-1:0] n_stores;
    t_outcome       w_outcome;

    dmsc_collect #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_ccmd),
        .i_data_byte (i_data_byte),
        .i_rd_idx    (r_idx),
        .o_rd_byte   (w_buf_byte),
        .o_hash      (w_hash),
        .o_count     (w_count)
    );

    dmsc_entry #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) u_entry (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_ecmd),
        .i_slot      (w_ent_slot),
        .i_rd_idx    (r_idx),
        .i_wr_idx    (r_cidx),
        .i_wr_byte   (w_buf_byte),
        .i_len_wdata (r_len),
        .o_txt_rdata (w_txt_rdata),
        .o_len_rdata (w_len_rdata),
        .o_busy      (w_clr_busy)
    );

    assign o_stall    = (r_state != ST_STREAM);
    assign w_accept   = i_valid && !o_stall;
    assign w_bypass   = (w_count == '0) || (w_count > CW'(MAX_LEN));
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_hit      = !r_diff && (w_len_rdata == r_len);
    assign w_store    = (r_state == ST_RESULT) && w_out_free && !r_bypass && !w_hit;
    assign n_stores   = (w_store && (r_stores != STW'(SLOTS))) ? r_stores + STW'(1)
                                                                 : r_stores;
    assign w_ent_slot = (r_state == ST_DECIDE) ? w_hash : r_slot;

    always_comb begin
        if (r_bypass) begin
            w_outcome = OUT_BYPASS;
        end else if (w_hit) begin
            w_outcome = OUT_HIT;
        end else begin
            w_outcome = OUT_MISS;
        end
    end

    always_comb begin
        n_state = r_state;
        w_ccmd  = '0;
        w_ecmd  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                if (!w_clr_busy) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                w_ccmd.take = w_accept && !i_empty_req;
                if (w_accept && i_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                w_ccmd.restart = 1'b1;
                w_ecmd.len_rd  = 1'b1;
                n_state = w_bypass ? ST_RESULT : ST_COMPARE;
            end
            ST_COMPARE: begin
                w_ccmd.rd_en  = 1'b1;
                w_ecmd.txt_rd = 1'b1;
                w_ecmd.txt_wr = r_cv;
                if (r_idx == IW'(r_len - LW'(1))) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                w_ecmd.txt_wr = r_cv;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                w_ecmd.len_wr = w_store;
                if (w_out_free) begin
                    n_state = ST_STREAM;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_stores <= '0;
            r_ovalid <= 1'b0;
            r_cv     <= 1'b0;
            r_diff   <= 1'b0;
            r_idx    <= '0;
            r_bypass <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_RESULT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_DECIDE: begin
                    r_bypass <= w_bypass;
                    r_slot   <= w_bypass ? '0 : w_hash;
                    r_len    <= w_bypass ? '0 : LW'(w_count);
                    r_idx    <= '0;
                    r_cv     <= 1'b0;
                    r_diff   <= 1'b0;
                end
                ST_COMPARE: begin
                    r_idx  <= r_idx + IW'(1);
                    r_cidx <= r_idx;
                    r_cv   <= 1'b1;
                    if (r_cv && (w_txt_rdata != w_buf_byte)) begin
                        r_diff <= 1'b1;
                    end
                end
                ST_TAIL: begin
                    r_cv <= 1'b0;
                    if (r_cv && (w_txt_rdata != w_buf_byte)) begin
                        r_diff <= 1'b1;
                    end
                end
                ST_RESULT: begin
                    if (w_out_free) begin
                        r_outcome <= w_outcome;
                        r_oslot   <= r_slot;
                        r_olen    <= r_len;
                        r_ostores <= n_stores;
                        r_stores  <= n_stores;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid   = r_ovalid;
    assign o_outcome = r_outcome;
    assign o_slot    = r_oslot;
    assign o_length  = r_olen;
    assign o_stores  = r_ostores;

endmodule
